// File: sv/fpalu_pkg.sv
// Shared types and constants for the fixed-point ALU.
// No dependencies.
package fpalu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DIV_N     = 32 + FRAC_BITS;   // numerator magnitude width
   localparam int QDEPTH    = 2;

   typedef enum logic [3:0] {
      FN_ADD  = 4'd0,
      FN_SUB  = 4'd1,
      FN_NEG  = 4'd2,
      FN_MUL  = 4'd3,
      FN_DIV  = 4'd4,
      FN_MIN  = 4'd5,
      FN_MAX  = 4'd6,
      FN_INC  = 4'd7,
      FN_DEC  = 4'd8,
      FN_ADDI = 4'd9,
      FN_SUBI = 4'd10
   } func_type;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
      logic               divide_by_zero;
   } rsp_type;

   // Classified item passed from front to back.
   typedef struct packed {
      logic               is_div;
      logic               is_mul;
      logic               div_zero;
      logic               neg_q;
      logic [31:0]        simple;      // result of the ops other than MUL and DIV
      logic signed [31:0] mul_a;
      logic signed [31:0] mul_b;
      logic [DIV_N-1:0]   num_mag;
      logic [31:0]        den_mag;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
   } item_type;

endpackage

// File: sv/fpalu_front.sv
// Front end: accepts requests, computes compare flags and simple results,
// classifies the item and pushes it into a small queue. Uses fpalu_pkg.
module fpalu_front import fpalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     q_valid,
   input  logic     q_ready,
   output item_type q_item
);

   item_type                 mem_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [$clog2(QDEPTH):0]   cnt_ff, cnt_in;
   item_type                 cls;
   logic                     push, pop;
   logic [31:0]              ua, ub, bsh;
   logic signed [DIV_N-1:0]  num;

   always_comb begin
      ua  = req_data.operand_a;
      ub  = req_data.operand_b;
      bsh = ub << FRAC_BITS;
      num = DIV_N'(req_data.operand_a) <<< FRAC_BITS;
      cls = '0;
      cls.a_greater = req_data.operand_a > req_data.operand_b;
      cls.a_less    = req_data.operand_a < req_data.operand_b;
      cls.a_equal   = ua == ub;
      cls.mul_a     = req_data.operand_a;
      cls.mul_b     = req_data.operand_b;
      cls.num_mag   = num[DIV_N-1] ? DIV_N'(-num) : DIV_N'(num);
      cls.den_mag   = ub[31] ? 32'(-ub) : ub;
      cls.neg_q     = num[DIV_N-1] ^ ub[31];
      unique case (req_data.func)
         FN_ADD:  cls.simple = ua + ub;
         FN_SUB:  cls.simple = ua - ub;
         FN_NEG:  cls.simple = 32'(0) - ua;
         FN_MUL:  cls.is_mul = 1'b1;
         FN_DIV:  begin
            cls.is_div   = ub != '0;
            cls.div_zero = ub == '0;
         end
         FN_MIN:  cls.simple = cls.a_greater ? ub : ua;
         FN_MAX:  cls.simple = cls.a_less ? ub : ua;
         FN_INC:  cls.simple = ua + 32'd1;
         FN_DEC:  cls.simple = ua - 32'd1;
         FN_ADDI: cls.simple = ua + bsh;
         FN_SUBI: cls.simple = ua - bsh;
         default: cls.simple = '0;
      endcase
   end

   assign req_ready = cnt_ff != QDEPTH;
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != '0;
   assign pop       = q_valid && q_ready;
   assign q_item    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= cls;
   end

endmodule

// File: sv/fpalu_back.sv
// Back end: pipeline of DIV_N restoring-divider stages (one quotient bit
// per stage) behind the entry stage that registers the product. Uses fpalu_pkg.
module fpalu_back import fpalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_ready,
   input  item_type q_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int NS = DIV_N;

   typedef struct packed {
      item_type         it;
      logic [32:0]      rem;
      logic [DIV_N-1:0] quo;
   } stage_type;

   stage_type          st_ff [NS+1];
   logic [NS:0]        v_ff;
   logic [NS:0]        adv;
   logic               done_valid;
   rsp_type            out_data;
   logic [31:0]        q32;
   logic signed [63:0] prod_ff;
   logic [63:0]        psh;

   // Advance when the next slot is free or moves on too.
   always_comb begin
      adv[NS] = !v_ff[NS] || rsp_ready;
      for (int i = NS - 1; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
   end
   assign q_ready = adv[0];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st_ff[0].it  <= q_item;
         st_ff[0].rem <= '0;
         st_ff[0].quo <= q_item.num_mag;
         prod_ff      <= q_item.mul_a * q_item.mul_b;
      end
      for (int i = 1; i <= NS; i++) begin
         if (adv[i]) begin
            logic [32:0] r;
            logic [33:0] t;
            item_type    nx;
            r  = {st_ff[i-1].rem[31:0], st_ff[i-1].quo[DIV_N-1]};
            t  = {1'b0, r} - {2'b0, st_ff[i-1].it.den_mag};
            nx = st_ff[i-1].it;
            // drop the shifted product into the result slot after the multiplier
            if (i == 1 && nx.is_mul) nx.simple = psh[31:0];
            st_ff[i].it <= nx;
            if (!t[33]) begin
               st_ff[i].rem <= t[32:0];
               st_ff[i].quo <= {st_ff[i-1].quo[DIV_N-2:0], 1'b1};
            end else begin
               st_ff[i].rem <= r;
               st_ff[i].quo <= {st_ff[i-1].quo[DIV_N-2:0], 1'b0};
            end
         end
      end
   end

   assign psh = 64'(prod_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= q_valid;
         for (int i = 1; i <= NS; i++)
            if (adv[i]) v_ff[i] <= v_ff[i-1];
      end
   end

   always_comb begin
      q32 = st_ff[NS].quo[31:0];
      out_data = '0;
      out_data.a_greater      = st_ff[NS].it.a_greater;
      out_data.a_less         = st_ff[NS].it.a_less;
      out_data.a_equal        = st_ff[NS].it.a_equal;
      out_data.divide_by_zero = st_ff[NS].it.div_zero;
      if (st_ff[NS].it.is_div)
         out_data.result_value = st_ff[NS].it.neg_q ? 32'(-q32) : q32;
      else
         out_data.result_value = st_ff[NS].it.simple;
   end

   assign done_valid = v_ff[NS];
   assign rsp_valid  = done_valid;
   assign rsp_data   = out_data;

endmodule

// File: sv/fixed_point_alu_core.sv
// Top level of the fixed-point ALU: front classifier, queue and back pipeline.
// Depends on fpalu_pkg, fpalu_front, fpalu_back.
//
// Usage:
//   req_valid/req_ready/req_data carry {func, operand_a, operand_b}.
//   rsp_valid/rsp_ready/rsp_data carry {result_value, compare flags,
//   divide_by_zero}; one response per request, in order.
//   Each item takes a two-entry queue hop, one entry stage that registers the
//   product, and a pipeline of 32+FRAC_BITS divider stages (one quotient bit
//   per stage) whose last stage drives rsp_data directly, with every
//   operation passing the same stages so order is kept.
//   Throughput is one item per cycle while rsp_ready is high.
//   Reset clears all valid flags and queue pointers; no item is in flight
//   afterwards. When the receiver stalls, the pipeline fills up and the
//   queue absorbs two more items before req_ready drops.
module fixed_point_alu_core import fpalu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     q_valid, q_ready;
   item_type q_item;

   fpalu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_item
   );

   fpalu_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
